// ----- design/aecc_pkg.sv -----
// ----------------------------------------------------------------------------
// aecc_pkg
// Shared widths, codes and controller/datapath interface types for the
// absolute encoder cross-check block.
// ----------------------------------------------------------------------------
package aecc_pkg;

    localparam int ADC_BITS  = 10;
    localparam int TICK_W    = 32;
    localparam int TOL_W     = 31;
    localparam int DIFF_W    = ADC_BITS + 1;              // adc - zero, signed
    localparam int PROD_W    = TICK_W + DIFF_W;           // signed numerator
    localparam int MAG_W     = PROD_W - 1;                // numerator magnitude
    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CMPD_W    = TICK_W + 1;                // q - motor, signed

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // action codes
    localparam logic [1:0] ACT_CAP_LIMIT = 2'd0;
    localparam logic [1:0] ACT_CAP_ZERO  = 2'd1;
    localparam logic [1:0] ACT_CHECK     = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNCAL    = 2'd1;
    localparam logic [1:0] ST_ZERO_SPN = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_TOL    = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_init;
        logic div_step;
        logic sat;
        logic cmp;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fast;     // result known at accept, no arithmetic needed
    } t_sts;

endpackage

// ----- design/aecc_ctrl.sv -----
// ----------------------------------------------------------------------------
// aecc_ctrl
// Sequencer: accepts one item, steps the datapath through multiply, divide,
// saturate and compare unless fast, then hands on to the output register.
// ----------------------------------------------------------------------------
module aecc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  aecc_pkg::t_sts    i_sts,
    output aecc_pkg::t_cmd    o_cmd
);
    import aecc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DINIT = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SAT   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = i_sts.fast ? S_DONE : S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                n_cnt        = CNT_W'(DIV_STEPS - 1);
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                cmd.sat = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                cmd.cmp = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- design/aecc_dp.sv -----
// ----------------------------------------------------------------------------
// aecc_dp
// Datapath: calibration readings, numerator multiply, bit-serial restoring
// divider, saturation, tolerance compare and output register.
// ----------------------------------------------------------------------------
module aecc_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  aecc_pkg::t_cmd                         i_cmd,
    output aecc_pkg::t_sts                         o_sts,
    input  logic [1:0]                             i_action,
    input  logic [aecc_pkg::ADC_BITS-1:0]          i_adc_sample,
    input  logic signed [aecc_pkg::TICK_W-1:0]     i_motor_count,
    input  logic signed [aecc_pkg::TICK_W-1:0]     i_zero_offset,
    input  logic [aecc_pkg::TOL_W-1:0]             i_tolerance,
    output logic signed [aecc_pkg::TICK_W-1:0]     o_abs_ticks,
    output logic                                   o_correct_count,
    output logic [1:0]                             o_status
);
    import aecc_pkg::*;

    localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'(64'h7FFF_FFFF);
    localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'h8000_0000);

    // calibration state
    logic [ADC_BITS-1:0]             r_limit, r_zero;
    logic                            r_cal;
    // item operands
    logic [ADC_BITS-1:0]             r_adc;
    logic signed [TICK_W-1:0]        r_motor;
    // arithmetic
    logic signed [PROD_W-1:0]        r_prod;
    logic [MAG_W-1:0]                r_dvd;      // dividend shifts out, quotient in
    logic [ADC_BITS-1:0]             r_rem;
    logic [ADC_BITS-1:0]             r_div;
    logic                            r_qneg;
    logic signed [TICK_W-1:0]        r_q;
    // result and output
    logic signed [TICK_W-1:0]        r_res_abs, r_out_abs;
    logic                            r_res_corr, r_out_corr;
    logic [1:0]                      r_res_status, r_out_status;

    logic                            span_zero;
    logic [1:0]                      fast_status;
    logic                            fast;
    logic signed [DIFF_W-1:0]        adc_diff;
    logic signed [DIFF_W-1:0]        span;
    logic signed [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]               prod_abs;
    logic [ADC_BITS:0]               trial;
    logic [ADC_BITS:0]               trial_sub;
    logic signed [TICK_W-1:0]        q_sat;
    logic signed [CMPD_W-1:0]        cmp_diff;
    logic [CMPD_W-1:0]               cmp_mag;

    assign span_zero = (r_zero == r_limit);

    always_comb begin
        fast        = 1'b1;
        fast_status = ST_OK;
        if (i_action == ACT_CHECK) begin
            if (!r_cal) begin
                fast_status = ST_UNCAL;
            end else if (span_zero) begin
                fast_status = ST_ZERO_SPN;
            end else begin
                fast = 1'b0;
            end
        end
    end

    assign o_sts.fast = fast;

    assign adc_diff = $signed({1'b0, r_adc}) - $signed({1'b0, r_zero});
    assign span     = $signed({1'b0, r_zero}) - $signed({1'b0, r_limit});
    assign prod     = PROD_W'(i_zero_offset) * PROD_W'(adc_diff);
    assign prod_abs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // restoring divide step
    assign trial     = {r_rem, r_dvd[MAG_W-1]};
    assign trial_sub = trial - {1'b0, r_div};

    always_comb begin
        if (r_qneg) begin
            q_sat = (r_dvd > MAG_NEG_MAX) ? $signed(TICK_W'(MAG_NEG_MAX))
                                          : TICK_W'(-$signed({1'b0, r_dvd}));
        end else begin
            q_sat = (r_dvd > MAG_POS_MAX) ? $signed(TICK_W'(MAG_POS_MAX))
                                          : $signed(r_dvd[TICK_W-1:0]);
        end
    end

    assign cmp_diff = CMPD_W'(r_q) - CMPD_W'(r_motor);
    assign cmp_mag  = cmp_diff[CMPD_W-1] ? CMPD_W'(-cmp_diff) : CMPD_W'(cmp_diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_zero  <= '0;
            r_cal   <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_action == ACT_CAP_LIMIT) begin
                r_limit <= i_adc_sample;
                r_cal   <= 1'b0;
            end else if (i_action == ACT_CAP_ZERO) begin
                r_zero <= i_adc_sample;
                r_cal  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_adc        <= i_adc_sample;
            r_motor      <= i_motor_count;
            r_res_abs    <= '0;
            r_res_corr   <= 1'b0;
            r_res_status <= fast_status;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.div_init) begin
            r_dvd  <= prod_abs[MAG_W-1:0];
            r_rem  <= '0;
            r_div  <= span[DIFF_W-1] ? ADC_BITS'(-span) : ADC_BITS'(span);
            r_qneg <= r_prod[PROD_W-1] ^ span[DIFF_W-1];
        end
        if (i_cmd.div_step) begin
            if (!trial_sub[ADC_BITS]) begin
                r_rem <= trial_sub[ADC_BITS-1:0];
                r_dvd <= {r_dvd[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[ADC_BITS-1:0];
                r_dvd <= {r_dvd[MAG_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sat) begin
            r_q <= q_sat;
        end
        if (i_cmd.cmp) begin
            r_res_abs    <= r_q;
            r_res_corr   <= (cmp_mag > CMPD_W'(i_tolerance));
            r_res_status <= ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_abs    <= r_res_abs;
            r_out_corr   <= r_res_corr;
            r_out_status <= r_res_status;
        end
    end

    assign o_abs_ticks     = r_out_abs;
    assign o_correct_count = r_out_corr;
    assign o_status        = r_out_status;

endmodule

// ----- design/absolute_encoder_cross_check.sv -----
// ----------------------------------------------------------------------------
// absolute_encoder_cross_check
// Two-point calibration of an analog absolute encoder and cross-check
// against the motor quadrature count.
// ----------------------------------------------------------------------------
// One item at a time. Captures and checks that fail early (not calibrated,
// zero span) go straight from acceptance to the output register; a full
// check steps through multiply, divider load, the bit-serial restoring
// divider retiring one quotient bit per cycle over the 42-bit numerator
// magnitude, saturate and compare. A result waits in the output register
// while the next item is taken. Registers: 0x0 zero offset ticks (signed),
// 0x4 tolerance ticks (31 bits); write them only while the block is idle.
// ----------------------------------------------------------------------------
module absolute_encoder_cross_check (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [aecc_pkg::PADDR_W-1:0]           paddr,
    input  logic [aecc_pkg::PDATA_W-1:0]           pwdata,
    output logic [aecc_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready,
    // input items
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_action,
    input  logic [aecc_pkg::ADC_BITS-1:0]          i_adc_sample,
    input  logic signed [aecc_pkg::TICK_W-1:0]     i_motor_count,
    // results
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [aecc_pkg::TICK_W-1:0]     o_abs_ticks,
    output logic                                   o_correct_count,
    output logic [1:0]                             o_status
);
    import aecc_pkg::*;

    logic signed [TICK_W-1:0] r_zero_offset;
    logic [TOL_W-1:0]         r_tolerance;
    logic                     reg_idx;
    logic                     wr_en;
    t_cmd                     cmd;
    t_sts                     sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= '0;
            r_tolerance   <= '0;
        end else if (wr_en) begin
            if (reg_idx == REG_OFFSET) begin
                r_zero_offset <= $signed(pwdata[TICK_W-1:0]);
            end else begin
                r_tolerance <= pwdata[TOL_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_TOL) begin
            prdata = {1'b0, r_tolerance};
        end else begin
            prdata = r_zero_offset;
        end
    end

    aecc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    aecc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_adc_sample    (i_adc_sample),
        .i_motor_count   (i_motor_count),
        .i_zero_offset   (r_zero_offset),
        .i_tolerance     (r_tolerance),
        .o_abs_ticks     (o_abs_ticks),
        .o_correct_count (o_correct_count),
        .o_status        (o_status)
    );

endmodule

// ----- tb/tb_absolute_encoder_cross_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_absolute_encoder_cross_check
// Self-checking bench for the absolute encoder cross-check block. A queue of
// pending items feeds a clocked driver. A clocked monitor compares every
// result transfer with the predicted result. Directed calibration cases
// come first, then random calibrate-and-check sequences over several
// register settings, with random idling on both sides and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_absolute_encoder_cross_check;
    import aecc_pkg::*;

    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam longint      TICK_MAX    = 64'sd2147483647;
    localparam longint      TICK_MIN    = -64'sd2147483648;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 60;
    localparam int          GAP_NONE    = 0;
    localparam int          GAP_FULL    = 1;
    localparam int          GAP_SPARSE  = 2;

    typedef struct {
        logic [1:0]                action;
        logic [ADC_BITS-1:0]       adc;
        logic signed [TICK_W-1:0]  motor;
    } t_enc_item;

    typedef struct {
        logic signed [TICK_W-1:0]  ticks;
        logic                      corr;
        logic [1:0]                status;
    } t_enc_result;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        psel           = 1'b0;
    logic                        penable        = 1'b0;
    logic                        pwrite         = 1'b0;
    logic [PADDR_W-1:0]          paddr          = '0;
    logic [PDATA_W-1:0]          pwdata         = '0;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_action       = '0;
    logic [ADC_BITS-1:0]         i_adc_sample   = '0;
    logic signed [TICK_W-1:0]    i_motor_count  = '0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic signed [TICK_W-1:0]    o_abs_ticks;
    logic                        o_correct_count;
    logic [1:0]                  o_status;

    absolute_encoder_cross_check u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_adc_sample    (i_adc_sample),
        .i_motor_count   (i_motor_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_abs_ticks     (o_abs_ticks),
        .o_correct_count (o_correct_count),
        .o_status        (o_status)
    );

    always #2 i_clk = ~i_clk;

    t_enc_item   pending_items[$];
    t_enc_result expected_results[$];
    t_enc_item   cur_item;

    // register shadows
    logic signed [TICK_W-1:0] cfg_offset = '0;
    logic [TOL_W-1:0]         cfg_tol    = '0;

    // calibration pair as the block holds it
    logic [ADC_BITS-1:0] cal_limit = '0;
    logic [ADC_BITS-1:0] cal_zero  = '0;
    logic                cal_done  = 1'b0;

    // calibration pair as the generator has queued it
    logic [ADC_BITS-1:0] gen_limit = '0;
    logic [ADC_BITS-1:0] gen_zero  = '0;
    logic                gen_done  = 1'b0;

    int          gap_mode   = GAP_FULL;
    int unsigned drv_wait   = 0;
    int unsigned rsp_wait   = 0;
    int unsigned hold_cnt   = 0;
    logic        hold_req   = 1'b0;
    logic        hold_ack   = 1'b0;

    int unsigned n_errors   = 0;
    int unsigned n_results  = 0;
    int unsigned n_items    = 0;
    int unsigned n_captures = 0;
    int unsigned n_checks   = 0;
    int unsigned n_corrects = 0;
    int unsigned n_clamped  = 0;
    int unsigned n_uncal    = 0;
    int unsigned n_nospan   = 0;
    int unsigned n_ignored  = 0;
    int unsigned n_cfg      = 0;

    // Scaled position, truncated toward zero and clamped to 32 bits.
    function automatic longint abs_position(input logic signed [TICK_W-1:0] offset,
                                            input logic [ADC_BITS-1:0] adc,
                                            input logic [ADC_BITS-1:0] zero,
                                            input logic [ADC_BITS-1:0] limit);
        longint span;
        longint num;
        longint q;
        span = longint'(zero) - longint'(limit);
        num  = longint'(offset) * (longint'(adc) - longint'(zero));
        q    = num / span;
        if (q > TICK_MAX) q = TICK_MAX;
        if (q < TICK_MIN) q = TICK_MIN;
        return q;
    endfunction

    function automatic t_enc_result predict_result(input t_enc_item it);
        t_enc_result r;
        longint      q;
        longint      num;
        longint      diff;
        r.ticks  = '0;
        r.corr   = 1'b0;
        r.status = ST_OK;
        n_items++;
        case (it.action)
            ACT_CAP_LIMIT: begin
                cal_limit = it.adc;
                cal_done  = 1'b0;
                n_captures++;
            end
            ACT_CAP_ZERO: begin
                cal_zero = it.adc;
                cal_done = 1'b1;
                n_captures++;
            end
            ACT_CHECK: begin
                n_checks++;
                if (!cal_done) begin
                    r.status = ST_UNCAL;
                    n_uncal++;
                end else if (cal_zero == cal_limit) begin
                    r.status = ST_ZERO_SPN;
                    n_nospan++;
                end else begin
                    q   = abs_position(cfg_offset, it.adc, cal_zero, cal_limit);
                    num = longint'(cfg_offset) * (longint'(it.adc) - longint'(cal_zero));
                    if (q == TICK_MAX || q == TICK_MIN) begin
                        if (num / (longint'(cal_zero) - longint'(cal_limit)) != q)
                            n_clamped++;
                    end
                    diff = q - longint'(it.motor);
                    if (diff < 0) diff = -diff;
                    r.ticks = q[TICK_W-1:0];
                    r.corr  = (diff > longint'(cfg_tol));
                    if (r.corr) n_corrects++;
                end
            end
            default: n_ignored++;
        endcase
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        case (gap_mode)
            GAP_NONE: return 0;
            GAP_FULL: return $urandom_range(0, 14);
            default:  return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        $display("[%0t] result %0d %s: got %0d, expected %0d", $time, n_results, what,
                 got, want);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        logic        v;
        int unsigned g;
        v = i_in_valid;
        g = drv_wait;
        if (!i_rst_n) begin
            v = 1'b0;
            g = 0;
        end else begin
            if (v && !o_in_stall) begin
                expected_results.push_back(predict_result(cur_item));
                v = 1'b0;
                g = draw_gap();
            end
            if (!v) begin
                if (g != 0) begin
                    g = g - 1;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    i_action      <= cur_item.action;
                    i_adc_sample  <= cur_item.adc;
                    i_motor_count <= cur_item.motor;
                    v = 1'b1;
                end
            end
        end
        i_in_valid <= v;
        drv_wait   <= g;
    end

    // long output hold-off, started by a toggle of hold_req
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req != hold_ack) begin
            hold_cnt <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_enc_result want;
        int unsigned w;
        w = rsp_wait;
        if (!i_rst_n) begin
            w = 0;
        end else if (o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, abs_ticks", longint'(o_abs_ticks),
                                longint'(0));
            end else begin
                want = expected_results.pop_front();
                if (o_abs_ticks !== want.ticks)
                    report_mismatch("abs_ticks", longint'(o_abs_ticks),
                                    longint'(want.ticks));
                if (o_correct_count !== want.corr)
                    report_mismatch("correct_count", longint'(o_correct_count),
                                    longint'(want.corr));
                if (o_status !== want.status)
                    report_mismatch("status", longint'(o_status), longint'(want.status));
            end
            w = draw_gap();
        end else if (w != 0) begin
            w = w - 1;
        end
        rsp_wait    <= w;
        i_out_stall <= (w != 0) || (hold_cnt > 1);
    end

    // ---------------- stimulus ----------------
    task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] rd_want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_OFFSET) cfg_offset = value;
        else                       cfg_tol    = value[TOL_W-1:0];
        n_cfg++;
        // read back the register just written
        @(negedge i_clk);
        rd_want = (reg_sel == REG_OFFSET) ? cfg_offset : {1'b0, cfg_tol};
        if (pready !== 1'b1)
            report_mismatch("pready", longint'(pready), longint'(1'b1));
        if (prdata !== rd_want)
            report_mismatch("register readback", longint'(prdata), longint'(rd_want));
    endtask

    task automatic set_config(input logic signed [TICK_W-1:0] offset,
                              input logic [TOL_W-1:0] tol);
        apb_write(REG_OFFSET, offset);
        apb_write(REG_TOL, {1'b0, tol});
    endtask

    task automatic push_item(input logic [1:0] action, input logic [ADC_BITS-1:0] adc,
                             input logic signed [TICK_W-1:0] motor);
        t_enc_item it;
        it.action = action;
        it.adc    = adc;
        it.motor  = motor;
        pending_items.push_back(it);
        if (action == ACT_CAP_LIMIT) begin
            gen_limit = adc;
            gen_done  = 1'b0;
        end else if (action == ACT_CAP_ZERO) begin
            gen_zero = adc;
            gen_done = 1'b1;
        end
    endtask

    // wait until every item is through and every result is in
    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic logic [ADC_BITS-1:0] pick_adc();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
        endcase
    endfunction

    // motor count half the time near the position the block will compute
    function automatic logic signed [TICK_W-1:0] pick_motor(input logic [ADC_BITS-1:0] adc);
        longint q;
        longint m;
        q = 0;
        if (gen_done && gen_zero != gen_limit)
            q = abs_position(cfg_offset, adc, gen_zero, gen_limit);
        case ($urandom_range(0, 5))
            0, 1: begin
                // straddle the tolerance edge
                m = longint'(cfg_tol) + longint'($urandom_range(0, 2)) - 1;
                m = $urandom_range(0, 1) ? q + m : q - m;
            end
            2:       m = q + longint'($urandom_range(0, 20)) - 10;
            3:       m = $urandom_range(0, 1) ? TICK_MAX : TICK_MIN;
            default: m = longint'($signed($urandom()));
        endcase
        if (m > TICK_MAX) m = TICK_MAX;
        if (m < TICK_MIN) m = TICK_MIN;
        return m[TICK_W-1:0];
    endfunction

    task automatic queue_random_run(input int unsigned n_want);
        int unsigned         k;
        int unsigned         n_chk;
        logic [ADC_BITS-1:0] a_lim;
        logic [ADC_BITS-1:0] a_zero;
        logic [ADC_BITS-1:0] a;
        logic [1:0]          act;
        k = 0;
        while (k < n_want) begin
            case ($urandom_range(0, 9))
                7: begin
                    // limit captured but zero never retaken
                    a = pick_adc();
                    push_item(ACT_CAP_LIMIT, a, $urandom());
                    k++;
                    n_chk = $urandom_range(1, 3);
                    repeat (n_chk) begin
                        a = pick_adc();
                        push_item(ACT_CHECK, a, pick_motor(a));
                        k++;
                    end
                end
                8, 9: begin
                    act = 2'($urandom_range(0, 3));
                    a   = ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
                    push_item(act, a, $urandom());
                    if (act != ACT_UNUSED) k++;
                end
                default: begin
                    a_lim  = pick_adc();
                    a_zero = pick_adc();
                    case ($urandom_range(0, 11))
                        0:       a_zero = a_lim;
                        1:       a_zero = (a_lim == '1) ? a_lim - 1'b1 : a_lim + 1'b1;
                        2:       a_zero = (a_lim == '0) ? a_lim + 1'b1 : a_lim - 1'b1;
                        default: ;
                    endcase
                    push_item(ACT_CAP_LIMIT, a_lim, $urandom());
                    push_item(ACT_CAP_ZERO, a_zero, $urandom());
                    k += 2;
                    n_chk = $urandom_range(1, 8);
                    repeat (n_chk) begin
                        a = pick_adc();
                        push_item(ACT_CHECK, a, pick_motor(a));
                        k++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: calibration order, equal readings, rounding, tolerance edge
        gap_mode = GAP_FULL;
        set_config(32'sd1000, 31'd5);
        push_item(ACT_CHECK,     10'd300,  32'sd0);
        push_item(ACT_UNUSED,    10'd1023, -32'sd1);
        push_item(ACT_CAP_LIMIT, 10'd0,    32'sd0);
        push_item(ACT_CAP_ZERO,  10'd0,    32'sd0);
        push_item(ACT_CHECK,     10'd512,  32'sd0);
        push_item(ACT_CAP_ZERO,  10'd1023, 32'sd0);
        push_item(ACT_CHECK,     10'd0,    -32'sd1000);
        push_item(ACT_CHECK,     10'd1023, 32'sh7FFF_FFFF);
        push_item(ACT_CHECK,     10'd511,  32'sh8000_0000);
        push_item(ACT_CHECK,     10'd700,  -32'sd310);
        push_item(ACT_CHECK,     10'd700,  -32'sd309);
        push_item(ACT_UNUSED,    10'd5,    32'sd7);
        push_item(ACT_CHECK,     10'd1023, 32'sd0);
        push_item(ACT_CAP_LIMIT, 10'd1023, 32'sd0);
        push_item(ACT_CHECK,     10'd0,    32'sd0);
        drain();

        // clamping at both bounds with a negative span
        set_config(32'sh8000_0000, 31'h7FFF_FFFF);
        push_item(ACT_CAP_LIMIT, 10'd1023, 32'sd0);
        push_item(ACT_CAP_ZERO,  10'd1022, 32'sd0);
        push_item(ACT_CHECK,     10'd0,    32'sh7FFF_FFFF);
        push_item(ACT_CHECK,     10'd1023, 32'sh8000_0000);
        push_item(ACT_CHECK,     10'd1022, 32'sd0);
        drain();

        set_config(32'sh7FFF_FFFF, 31'd0);
        push_item(ACT_CAP_LIMIT, 10'd0,    32'sd0);
        push_item(ACT_CAP_ZERO,  10'd1,    32'sd0);
        push_item(ACT_CHECK,     10'd1023, 32'sd0);
        push_item(ACT_CHECK,     10'd1,    32'sd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config($urandom(), TOL_W'($urandom()));
                1: set_config(int'($urandom_range(0, 10000)) - 5000,
                              TOL_W'($urandom_range(0, 50)));
                2: set_config(32'sh7FFF_FFFF, 31'd0);
                3: set_config(32'sh8000_0000, 31'h7FFF_FFFF);
                4: set_config(32'sd0, TOL_W'($urandom()));
                default: set_config(int'($urandom_range(0, 200000)) - 100000,
                                    TOL_W'($urandom_range(0, 1000)));
            endcase
            case (ph % 3)
                0:       gap_mode = GAP_FULL;
                1:       gap_mode = GAP_NONE;
                default: gap_mode = GAP_SPARSE;
            endcase
            queue_random_run(290);
            // output held off while items keep coming, so the input backs up
            if (ph == 2) hold_req = ~hold_req;
            drain();
        end

        $display("ran %0d items (%0d captures, %0d checks, %0d ignored codes), %0d results",
                 n_items, n_captures, n_checks, n_ignored, n_results);
        $display("%0d corrected, %0d clamped, %0d uncalibrated, %0d equal readings, %0d writes",
                 n_corrects, n_clamped, n_uncal, n_nospan, n_cfg);
        if (n_errors == 0) begin
            $display("absolute_encoder_cross_check: match");
        end else begin
            $display("absolute_encoder_cross_check: mismatch");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout waiting for results");
        $display("absolute_encoder_cross_check: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
design/aecc_pkg.sv
design/aecc_ctrl.sv
design/aecc_dp.sv
design/absolute_encoder_cross_check.sv
tb/tb_absolute_encoder_cross_check.sv
